>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the sector cache and zero-run coalescer.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication property on every rising clock edge outside reset.
`define SCZR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a plain condition on every rising clock edge outside reset.
`define SCZR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  `SCZR_ASSERT(label, clk, rst_n, (1'b1 |-> (cond)), msg)

`else

`define SCZR_ASSERT(label, clk, rst_n, prop, msg)
`define SCZR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/sczr_pkg.sv
// Types and constants for the sector cache and zero-run coalescer.
// Holds request and action codes, the controller states and the port widths.
// No dependencies.
package sczr_pkg;

  localparam int COUNT_W      = 8;
  localparam int RUN_W        = 24;
  localparam int OUT_SECTOR_W = 32;
  localparam int SLOT_W       = 6;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SYNC  = 2'd2;

  typedef enum logic [2:0] {
    ACT_FLUSH     = 3'd0,
    ACT_HIT       = 3'd1,
    ACT_DEV_READ  = 3'd2,
    ACT_DEV_WRITE = 3'd3,
    ACT_ABSORB    = 3'd4,
    ACT_SYNC_DONE = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLAIM,
    ST_EMIT_FLUSH,
    ST_EMIT_MAIN
  } state_t;

endpackage

>>> sv/sczr_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered, so it appears in the cycle after the address.
// No dependencies.
module sczr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sector_cache_and_zero_run_coalescer.sv
// Sector cache and zero-run coalescer: top level.
// Uses sczr_pkg for codes and widths, sczr_ram for the tag store, and
// assert_macros.svh for its checks.
//
// Requests come in on the in_ channel: in_tuser carries the command (read,
// write, sync) and the all-zero flag, in_tdata the first sector and the count.
// Each request with a known command gives one or two results on the out_
// channel: an optional flush of the pending zero run, then the request's own
// action with out_tlast high; the unused command code gives none. One request
// is in work at a time; in_tready is high while the controller is idle, also
// while the final result still waits in the output register. Reads and
// non-absorbed writes scan the whole tag memory, one entry a cycle through its
// read port, then claim a slot before their results are loaded; syncs and
// absorbed zero writes skip the scan and the claim. A stalled receiver holds
// the output register and the controller waits with it; no result is dropped.
// Reset empties the zero run, sets the replacement pointer to slot 0 and
// zeroes the count of filled slots, so no clearing pass is needed and a
// request is taken in the first cycle after reset.
module sector_cache_and_zero_run_coalescer #(
  parameter int CACHE_ENTRIES = 64,
  parameter int SECTOR_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] sector_addr, [39:32] sector_count
  input  logic [sczr_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] cmd, [2] all_zero
  input  logic [sczr_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] out_sector, [55:32] out_count, [61:56] slot, [63:62] zero
  output logic [sczr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] action
  output logic [sczr_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  import sczr_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);
  localparam int SUM_W = (SECTOR_BITS > RUN_W) ? SECTOR_BITS : RUN_W;

  // Request capture and run bookkeeping.
  state_t                  state_r, state_nxt;
  logic [1:0]              req_cmd_r;
  logic [SECTOR_BITS-1:0]  req_sector_r;
  logic [COUNT_W-1:0]      req_count_r;
  logic                    flush_pend_r;
  logic [SECTOR_BITS-1:0]  flush_start_r;
  logic [RUN_W-1:0]        flush_len_r;
  action_t                 main_act_r;
  logic [IDX_W-1:0]        main_slot_r;
  logic [SECTOR_BITS-1:0]  run_start_r;
  logic [RUN_W-1:0]        run_len_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [IDX_W:0]          fill_r;

  // Tag scan pipeline.
  logic [IDX_W-1:0]        scan_idx_r;
  logic                    cmp_vld_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        found_idx_r;
  logic [SECTOR_BITS-1:0]  tag_rdata;

  // Output register.
  logic                    out_vld_r;
  action_t                 out_act_r;
  logic [OUT_SECTOR_W-1:0] out_sector_r;
  logic [RUN_W-1:0]        out_count_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic                    out_last_r;

  // Input decode.
  logic [1:0]              in_cmd;
  logic                    in_zero;
  logic [SECTOR_BITS-1:0]  in_sector;
  logic [COUNT_W-1:0]      in_count;
  logic                    in_acc;
  logic                    run_active;
  logic [SUM_W-1:0]        run_end_sum;
  logic [SECTOR_BITS-1:0]  run_end;
  logic [RUN_W:0]          run_grow;
  logic                    contig;
  logic                    acc_flush;
  logic                    acc_absorb;
  logic                    acc_scan;
  logic                    acc_known;
  action_t                 acc_act;

  // Controller strobes and claim decision.
  logic                    out_free;
  logic                    ld_flush;
  logic                    ld_main;
  logic                    in_claim;
  logic                    tag_live;
  logic                    hit_cmp;
  logic                    read_hit;
  logic [IDX_W-1:0]        claim_slot;
  logic [IDX_W-1:0]        claim_ptr;
  logic                    tag_we;

  assign in_cmd    = in_tuser[1:0];
  assign in_zero   = in_tuser[2];
  assign in_sector = SECTOR_BITS'(in_tdata[31:0]);
  assign in_count  = in_tdata[39:32];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign run_active  = (run_len_r != '0);
  assign run_end_sum = SUM_W'(run_start_r) + SUM_W'(run_len_r);
  assign run_end     = run_end_sum[SECTOR_BITS-1:0];
  assign run_grow    = {1'b0, run_len_r} + (RUN_W + 1)'(in_count);
  assign contig      = !run_active || (in_sector == run_end);

  always_comb begin
    acc_flush  = 1'b0;
    acc_absorb = 1'b0;
    acc_scan   = 1'b0;
    acc_known  = 1'b1;
    acc_act    = ACT_SYNC_DONE;
    unique case (in_cmd)
      CMD_READ: begin
        acc_flush = run_active;
        acc_scan  = 1'b1;
        acc_act   = ACT_DEV_READ;
      end
      CMD_WRITE: begin
        if (contig && in_zero) begin
          // Absorbed; a run past its largest length is flushed and starts anew.
          acc_absorb = 1'b1;
          acc_flush  = run_active && run_grow[RUN_W];
          acc_act    = ACT_ABSORB;
        end else begin
          acc_flush = !contig;
          acc_scan  = 1'b1;
          acc_act   = ACT_DEV_WRITE;
        end
      end
      CMD_SYNC: begin
        acc_flush = run_active;
        acc_act   = ACT_SYNC_DONE;
      end
      default: begin
        acc_known = 1'b0;
      end
    endcase
  end

  // Tag store.
  sczr_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (CACHE_ENTRIES)
  ) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (claim_slot),
    .wdata (req_sector_r),
    .raddr (scan_idx_r),
    .rdata (tag_rdata)
  );

  // A slot is claimed either at the pointer or where its tag already matches,
  // so the written slots always form a prefix of the store that fill_r counts.
  assign tag_live = ({1'b0, cmp_idx_r} < fill_r);

  // Sector zero is never a hit, so a slot holding tag zero never matches.
  assign hit_cmp = cmp_vld_r && tag_live && (tag_rdata == req_sector_r) &&
                   (req_sector_r != '0);

  assign read_hit   = (req_cmd_r == CMD_READ) && (req_count_r == COUNT_W'(1)) && found_r;
  assign claim_slot = found_r ? found_idx_r : ptr_r;
  assign claim_ptr  = (claim_slot == IDX_LAST) ? '0 : claim_slot + IDX_W'(1);
  assign tag_we     = in_claim && !read_hit;
  assign out_free   = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    ld_flush  = 1'b0;
    ld_main   = 1'b0;
    in_claim  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && acc_known) begin
          if (acc_scan) begin
            state_nxt = ST_SCAN;
          end else if (acc_flush) begin
            state_nxt = ST_EMIT_FLUSH;
          end else begin
            state_nxt = ST_EMIT_MAIN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && (cmp_idx_r == IDX_LAST)) begin
          state_nxt = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        in_claim  = 1'b1;
        state_nxt = flush_pend_r ? ST_EMIT_FLUSH : ST_EMIT_MAIN;
      end
      ST_EMIT_FLUSH: begin
        if (out_free) begin
          ld_flush  = 1'b1;
          state_nxt = ST_EMIT_MAIN;
        end
      end
      ST_EMIT_MAIN: begin
        if (out_free) begin
          ld_main   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      run_len_r <= '0;
      ptr_r     <= '0;
      fill_r    <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (in_acc) begin
        found_r <= 1'b0;
        if (acc_absorb) begin
          run_len_r <= (acc_flush ? RUN_W'(0) : run_len_r) + RUN_W'(in_count);
        end else if (acc_flush) begin
          run_len_r <= '0;
        end
      end else if (hit_cmp) begin
        found_r <= 1'b1;
      end
      if (tag_we) begin
        ptr_r <= claim_ptr;
        if ({1'b0, claim_slot} == fill_r) begin
          fill_r <= fill_r + (IDX_W + 1)'(1);
        end
      end
      if (ld_flush || ld_main) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_cmd_r     <= in_cmd;
      req_sector_r  <= in_sector;
      req_count_r   <= in_count;
      flush_pend_r  <= acc_flush;
      flush_start_r <= run_start_r;
      flush_len_r   <= run_len_r;
      main_act_r    <= acc_act;
      main_slot_r   <= '0;
      scan_idx_r    <= '0;
      if (acc_absorb && (acc_flush || !run_active)) begin
        run_start_r <= in_sector;
      end
    end
    if (state_r == ST_SCAN && scan_idx_r != IDX_LAST) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (hit_cmp && !found_r) begin
      found_idx_r <= cmp_idx_r;
    end
    if (in_claim) begin
      main_slot_r <= claim_slot;
      if (read_hit) begin
        main_act_r <= ACT_HIT;
      end
    end
    if (ld_flush) begin
      out_act_r    <= ACT_FLUSH;
      out_sector_r <= OUT_SECTOR_W'(flush_start_r);
      out_count_r  <= flush_len_r;
      out_slot_r   <= '0;
      out_last_r   <= 1'b0;
    end else if (ld_main) begin
      out_act_r    <= main_act_r;
      out_sector_r <= (main_act_r == ACT_SYNC_DONE) ? '0 : OUT_SECTOR_W'(req_sector_r);
      out_count_r  <= (main_act_r == ACT_SYNC_DONE) ? '0 : RUN_W'(req_count_r);
      out_slot_r   <= SLOT_W'(main_slot_r);
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_slot_r, out_count_r, out_sector_r};

  `SCZR_ASSERT(a_flush_not_last, clk, rst_n,
    (out_tvalid && out_tuser == ACT_FLUSH) |-> !out_tlast, "flush result marked last")
  `SCZR_ASSERT(a_hit_single, clk, rst_n,
    (out_tvalid && out_tuser == ACT_HIT) |-> (out_tdata[55:32] == 24'd1),
    "cache hit on a multi-sector read")
  `SCZR_ASSERT(a_read_empties_run, clk, rst_n,
    (in_acc && in_cmd == CMD_READ) |=> (run_len_r == '0),
    "zero run left pending after a read")
  `SCZR_ASSERT(a_found_in_range, clk, rst_n,
    (state_r == ST_SCAN && found_r) |-> (found_idx_r <= cmp_idx_r),
    "match index beyond the scanned slots")

endmodule

>>> tb/sv/tb_sector_cache_and_zero_run_coalescer.sv
// Self-checking testbench for sector_cache_and_zero_run_coalescer.
// Depends on sczr_pkg for the command and action codes and the port widths.
// Requests go in through a queue-fed driver, and a monitor checks every action.
`timescale 1ns / 1ps

module tb_sector_cache_and_zero_run_coalescer;
  import sczr_pkg::*;

  localparam int          NUM_SLOTS      = 64;
  localparam int          POOL_SIZE      = 16;
  localparam int          RANDOM_PER_PHASE = 180;
  localparam int          RUN_LIMIT      = 24'hFFFFFF;
  localparam int          LONG_RUN_WRITES = 40;
  localparam int          HOLDOFF_CYCLES = 600;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          TAIL_CYCLES    = 150;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sector;
    logic [7:0]  count;
    logic        zero;
  } sector_req_t;

  typedef struct {
    action_t     act;
    logic [31:0] sector;
    logic [23:0] count;
    logic [5:0]  slot;
    logic        last;
  } action_rec_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_W-1:0]     in_tdata = '0;
  logic [IN_USER_W-1:0]     in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    out_tdata;
  logic [OUT_USER_W-1:0]    out_tuser;
  logic                     out_tlast;

  sector_req_t pending_reqs[$];
  action_rec_t expected_actions[$];
  sector_req_t offered_req = '0;
  sector_req_t next_req;

  // Shadow of the block's state.
  logic [31:0] tag_mem[NUM_SLOTS];
  logic [5:0]  victim_slot = '0;
  logic [31:0] zrun_start = '0;
  logic [23:0] zrun_len = '0;

  // Stimulus shaping state.
  logic [31:0] sector_pool[POOL_SIZE];
  logic [31:0] zw_cursor = 32'h0000_1000;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int reqs_taken = 0;
  int holdoff_at = 0;
  bit holdoff_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int errors = 0;

  sector_cache_and_zero_run_coalescer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic void expect_action(action_t a, logic [31:0] s, logic [23:0] n,
                                        logic [5:0] slot, logic last);
    action_rec_t rec;
    rec.act = a;
    rec.sector = s;
    rec.count = n;
    rec.slot = slot;
    rec.last = last;
    expected_actions.push_back(rec);
  endfunction

  function automatic int tag_lookup(logic [31:0] s);
    if (s == '0) return -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tag_mem[i] == s) return i;
    end
    return -1;
  endfunction

  function automatic logic [5:0] claim_slot(logic [31:0] s);
    int m;
    logic [5:0] k;
    m = tag_lookup(s);
    k = (m >= 0) ? 6'(m) : victim_slot;
    tag_mem[k] = s;
    victim_slot = k + 6'd1;
    return k;
  endfunction

  function automatic void flush_zero_run();
    expect_action(ACT_FLUSH, zrun_start, zrun_len, '0, 1'b0);
    zrun_len = '0;
  endfunction

  // Works out the actions one accepted request causes and updates the shadow state.
  function automatic void predict_actions(sector_req_t r);
    logic [31:0] run_end;
    int m;
    logic [5:0] s;
    case (r.cmd)
      CMD_READ: begin
        if (zrun_len != '0) flush_zero_run();
        m = (r.count == 8'd1) ? tag_lookup(r.sector) : -1;
        if (m >= 0) begin
          expect_action(ACT_HIT, r.sector, 24'(r.count), 6'(m), 1'b1);
        end else begin
          s = claim_slot(r.sector);
          expect_action(ACT_DEV_READ, r.sector, 24'(r.count), s, 1'b1);
        end
      end
      CMD_WRITE: begin
        run_end = zrun_start + 32'(zrun_len);
        if (zrun_len == '0 || r.sector == run_end) begin
          if (r.zero) begin
            if (zrun_len != '0 && int'(zrun_len) + int'(r.count) > RUN_LIMIT)
              flush_zero_run();
            if (zrun_len == '0) zrun_start = r.sector;
            zrun_len = zrun_len + 24'(r.count);
            expect_action(ACT_ABSORB, r.sector, 24'(r.count), '0, 1'b1);
            return;
          end
        end else begin
          flush_zero_run();
        end
        s = claim_slot(r.sector);
        expect_action(ACT_DEV_WRITE, r.sector, 24'(r.count), s, 1'b1);
      end
      CMD_SYNC: begin
        if (zrun_len != '0) flush_zero_run();
        expect_action(ACT_SYNC_DONE, '0, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] c, logic [31:0] s, logic [7:0] n, logic z);
    sector_req_t r;
    r.cmd = c;
    r.sector = s;
    r.count = n;
    r.zero = z;
    pending_reqs.push_back(r);
  endfunction

  // Mostly well-formed traffic: contiguous zero-write runs, re-reads of recent
  // sectors and contiguous data writes, with some fully random requests mixed in.
  function automatic sector_req_t random_req();
    sector_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.zero = 1'b0;
    r.count = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd1;
    r.sector = sector_pool[$urandom_range(POOL_SIZE - 1)];
    if (pick < 30) begin
      if ($urandom_range(9) == 0) zw_cursor = $urandom;
      r.cmd = CMD_WRITE;
      r.zero = 1'b1;
      r.sector = zw_cursor;
      zw_cursor = zw_cursor + 32'(r.count);
    end else if (pick < 55) begin
      r.cmd = CMD_READ;
    end else if (pick < 68) begin
      r.cmd = CMD_WRITE;
      if ($urandom_range(1) == 1) r.sector = zw_cursor;
    end else if (pick < 78) begin
      r.cmd = CMD_SYNC;
    end else if (pick < 88) begin
      r.cmd = 2'($urandom_range(3));
      r.sector = $urandom;
      r.count = 8'($urandom_range(255));
      r.zero = 1'($urandom_range(1));
    end else begin
      r.cmd = ($urandom_range(1) == 1) ? CMD_READ : CMD_WRITE;
      r.sector = $urandom;
      r.zero = 1'($urandom_range(1));
      sector_pool[$urandom_range(POOL_SIZE - 1)] = r.sector;
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Checks at falling edges, after every clocked update has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_actions.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_phase(int sidle, int rstall, bit with_holdoff);
    int made;
    sector_req_t r;
    made = 0;
    wait_drained();
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (with_holdoff) holdoff_at = reqs_taken + 20;
    while (made < RANDOM_PER_PHASE) begin
      r = random_req();
      pending_reqs.push_back(r);
      if (r.cmd != CMD_UNUSED) made++;
    end
  endtask

  // Request driver: presents the next queued request once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_actions(offered_req);
        reqs_taken <= reqs_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          offered_req <= next_req;
          in_tdata <= {next_req.count, next_req.sector};
          in_tuser <= {next_req.zero, next_req.cmd};
          in_tvalid <= 1'b1;
        end else begin
          in_tdata <= IN_DATA_W'({$urandom, $urandom});
          in_tuser <= IN_USER_W'($urandom);
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Action monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_actions.size() == 0) begin
          $error("unexpected action %0d at sector 0x%0h", out_tuser, out_tdata[31:0]);
          errors++;
        end else begin
          check_field("action", expected_actions[0].act, out_tuser);
          check_field("out_sector", expected_actions[0].sector, out_tdata[31:0]);
          check_field("out_count", expected_actions[0].count, out_tdata[55:32]);
          check_field("slot", expected_actions[0].slot, out_tdata[61:56]);
          check_field("pad", 0, out_tdata[63:62]);
          check_field("last", expected_actions[0].last, out_tlast);
          void'(expected_actions.pop_front());
        end
      end
      if (!holdoff_done && holdoff_at != 0 && reqs_taken >= holdoff_at) begin
        holdoff_done <= 1'b1;
        hold_left <= HOLDOFF_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no request or action moving.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] s;
    for (int i = 0; i < NUM_SLOTS; i++) tag_mem[i] = '0;
    sector_pool[0] = '0;
    for (int i = 1; i < POOL_SIZE; i++) sector_pool[i] = 32'(i * 37 + 5);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sector 0 never hits, so both reads go to the device.
    queue_req(CMD_READ, 32'h0000_0000, 8'd1, 1'b0);
    queue_req(CMD_READ, 32'h0000_0000, 8'd1, 1'b0);
    queue_req(CMD_WRITE, 32'hFFFF_FFFF, 8'd255, 1'b0);
    queue_req(CMD_READ, 32'hFFFF_FFFF, 8'd1, 1'b0);
    queue_req(CMD_READ, 32'hFFFF_FFFF, 8'd2, 1'b0);
    // Zero run, a zero-count extension, then a non-zero write right after it.
    queue_req(CMD_WRITE, 32'h0000_0010, 8'd4, 1'b1);
    queue_req(CMD_WRITE, 32'h0000_0014, 8'd0, 1'b1);
    queue_req(CMD_WRITE, 32'h0000_0014, 8'd1, 1'b0);
    queue_req(CMD_WRITE, 32'h0000_0014, 8'd3, 1'b1);
    // A zero write elsewhere flushes and is written out normally.
    queue_req(CMD_WRITE, 32'h0000_0100, 8'd1, 1'b1);
    // The tag of sector 0x20 goes stale after the absorbed zero write.
    queue_req(CMD_WRITE, 32'h0000_0020, 8'd1, 1'b0);
    queue_req(CMD_SYNC, 32'h0000_0000, 8'd0, 1'b0);
    queue_req(CMD_WRITE, 32'h0000_0020, 8'd1, 1'b1);
    queue_req(CMD_READ, 32'h0000_0020, 8'd1, 1'b0);
    queue_req(CMD_SYNC, 32'h5555_5555, 8'd85, 1'b1);
    queue_req(CMD_UNUSED, 32'hAAAA_AAAA, 8'd170, 1'b1);
    queue_req(CMD_READ, 32'h5555_5555, 8'd0, 1'b0);
    queue_req(CMD_WRITE, 32'hAAAA_AAAA, 8'd0, 1'b0);
    queue_req(CMD_WRITE, 32'hAAAA_AAAA, 8'd170, 1'b1);
    queue_req(CMD_SYNC, 32'h0000_0000, 8'd0, 1'b0);
    // The run end wraps past the top of the sector space.
    queue_req(CMD_WRITE, 32'hFFFF_FFFE, 8'd4, 1'b1);
    queue_req(CMD_WRITE, 32'h0000_0002, 8'd1, 1'b1);
    queue_req(CMD_READ, 32'h5555_5555, 8'd1, 1'b0);
    queue_req(CMD_READ, 32'hAAAA_AAAA, 8'd1, 1'b0);
    queue_req(CMD_SYNC, 32'h0000_0000, 8'd0, 1'b0);

    // Grow one long zero run over many contiguous writes, across the top of
    // the sector space.
    wait_drained();
    s = 32'hFFFF_FF00;
    for (int i = 0; i < LONG_RUN_WRITES; i++) begin
      queue_req(CMD_WRITE, s, 8'd255, 1'b1);
      s = s + 32'd255;
    end
    queue_req(CMD_SYNC, 32'h0000_0000, 8'd0, 1'b0);

    random_phase(0, 0, 1'b1);
    random_phase(73, 0, 1'b0);
    random_phase(0, 73, 1'b0);
    random_phase(26, 26, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_actions.size() != 0) begin
      $error("%0d expected actions never arrived", expected_actions.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sector_cache_and_zero_run_coalescer.f
+incdir+sv
sv/sczr_pkg.sv
sv/sczr_ram.sv
sv/sector_cache_and_zero_run_coalescer.sv
tb/sv/tb_sector_cache_and_zero_run_coalescer.sv
